/* src/ax25ui_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ax25ui_pkg;

	// result kinds
	localparam logic [2:0] KIND_CHAR    = 3'd0;
	localparam logic [2:0] KIND_SSID    = 3'd1;
	localparam logic [2:0] KIND_CONTROL = 3'd2;
	localparam logic [2:0] KIND_PID     = 3'd3;
	localparam logic [2:0] KIND_PAYLOAD = 3'd4;
	localparam logic [2:0] KIND_STATUS  = 3'd5;

	// frame status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_SHORT        = 3'd1;
	localparam logic [2:0] ST_NO_ADDR_END  = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR_LEN = 3'd3;
	localparam logic [2:0] ST_TOO_MANY     = 3'd4;
	localparam logic [2:0] ST_NOT_UI       = 3'd5;
	localparam logic [2:0] ST_BAD_PID      = 3'd6;
	localparam logic [2:0] ST_TOO_LONG     = 3'd7;

	// configuration register indexes
	localparam logic REG_MIN_LEN = 1'b0;
	localparam logic REG_PID     = 1'b1;

	localparam logic [7:0] PAD_BYTE    = 8'h40;  // space shifted left by one
	localparam logic [1:0] CTRL_UI     = 2'b11;
	localparam int         CALL_CHARS  = 6;
	localparam logic [9:0] PLEN_MAX    = 10'h3FF;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] address_index;
		logic [7:0] value;
		logic [2:0] status;
		logic [9:0] pay_len;
		logic       frame_end;
	} result_item_t;

	// what one frame byte leaves for the back end
	typedef struct packed {
		logic       item_v;
		logic [2:0] kind;
		logic [3:0] address_index;
		logic [7:0] value;
		logic       stat_v;
		logic [2:0] status;
		logic [9:0] pay_len;
	} queue_entry_t;

endpackage

`default_nettype wire

/* src/ax25ui_frame_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ax25ui_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* src/ax25ui_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ax25ui_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [3:0] address_index;
	logic [7:0] value;
	logic [2:0] status;
	logic [9:0] pay_len;
	logic       frame_end;

	modport source (output valid, output kind, output address_index, output value,
		output status, output pay_len, output frame_end, input ready);
	modport sink (input valid, input kind, input address_index, input value,
		input status, input pay_len, input frame_end, output ready);
endinterface

`default_nettype wire

/* src/ax25_ui_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Handshake       Carries
// frame     in    valid/ready     frame_byte, last_byte (one raw AX.25 byte, no flags/FCS)
// result    out   valid/ready     kind, address_index, value, status, pay_len, frame_end
// apb       in    psel/penable    min_frame_length at 0x0, expected_pid at 0x4
//
// Path: a byte is taken in the cycle it arrives; its result is registered in the queue,
// then in the output register. One byte per cycle holds while result is ready and each
// byte yields at most one transfer; a final byte that also yields an item sends item, then status.
// Reset: arst_n clears parse state, queue and output; registers return to 16 and 0xF0.
// Stalls: frame stalls only when the four-entry queue is full: under result back-pressure,
// or when short frames ending in two-transfer bytes outrun the single output register.

module ax25_ui_frame_parser #(
	parameter int MAX_ADDRESSES   = 10,
	parameter int MAX_FRAME_BYTES = 1023
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ax25ui_frame_if.sink     frame,
	ax25ui_result_if.source  result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import ax25ui_pkg::*;

	logic [9:0] min_len_q;
	logic [7:0] pid_q;
	logic       cfg_wr;

	logic         push, full, pop, head_v;
	queue_entry_t push_entry, head;

	// APB register file: writes land on the access phase, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= 10'd16;
			pid_q     <= 8'hF0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MIN_LEN: min_len_q <= pwdata[9:0];
				REG_PID:     pid_q     <= pwdata[7:0];
				default:     min_len_q <= min_len_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MIN_LEN: prdata = {22'd0, min_len_q};
			REG_PID:     prdata = {24'd0, pid_q};
			default:     prdata = 32'd0;
		endcase
	end

	// front: classify each byte, track address/control/pid/payload phases
	ax25ui_front #(
		.MAX_ADDRESSES   (MAX_ADDRESSES),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.frame            (frame),
		.min_frame_length (min_len_q),
		.expected_pid     (pid_q),
		.full             (full),
		.push             (push),
		.push_entry       (push_entry)
	);

	// queue: hold classified bytes while the output side stalls
	ax25ui_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_v     (head_v),
		.head       (head)
	);

	// back: serialize each entry into one or two result transfers
	ax25ui_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head_v (head_v),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire

/* src/ax25ui_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ax25ui_front #(
	parameter int MAX_ADDRESSES   = 10,
	parameter int MAX_FRAME_BYTES = 1023
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	ax25ui_frame_if.sink                 frame,
	input  wire logic [9:0]              min_frame_length,
	input  wire logic [7:0]              expected_pid,
	input  wire logic                    full,
	output logic                         push,
	output ax25ui_pkg::queue_entry_t     push_entry
);
	import ax25ui_pkg::*;

	localparam int BCW = $clog2(MAX_FRAME_BYTES + 2);
	localparam int CW  = (BCW > 10) ? BCW : 10;
	localparam logic [BCW-1:0] BC_LIMIT = BCW'(MAX_FRAME_BYTES);
	localparam logic [4:0]     ADDR_LIMIT = 5'(MAX_ADDRESSES);

	localparam logic [1:0] PH_ADDR = 2'd0;
	localparam logic [1:0] PH_CTRL = 2'd1;
	localparam logic [1:0] PH_PID  = 2'd2;
	localparam logic [1:0] PH_DATA = 2'd3;

	logic [BCW-1:0] bc_q, bc_n;
	logic [1:0]     phase_q, phase_n;
	logic [3:0]     addr_q, addr_n;
	logic [2:0]     bia_q, bia_n;
	logic           pad_q, pad_n;
	logic [2:0]     err_q, err_n;
	logic [9:0]     pc_q, pc_n;

	logic       it_v;
	logic [2:0] it_kind;
	logic [3:0] it_idx;
	logic [7:0] it_val;
	logic [2:0] stat;
	logic [7:0] b;
	logic       accept;

	assign b      = frame.frame_byte;
	assign frame.ready = !full;
	assign accept = frame.valid && !full;

	always_comb begin
		bc_n    = bc_q;
		phase_n = phase_q;
		addr_n  = addr_q;
		bia_n   = bia_q;
		pad_n   = pad_q;
		err_n   = err_q;
		pc_n    = pc_q;
		it_v    = 1'b0;
		it_kind = KIND_CHAR;
		it_idx  = 4'd0;
		it_val  = 8'd0;

		if (bc_q <= BC_LIMIT) begin
			bc_n = bc_q + 1'b1;
		end

		if (err_q == ST_OK && bc_n > BC_LIMIT) begin
			err_n = ST_TOO_LONG;
		end else if (err_q == ST_OK) begin
			case (phase_q)
				PH_ADDR: begin
					if (bia_q < 3'(CALL_CHARS)) begin
						if (b[0]) begin
							err_n = ST_BAD_ADDR_LEN;
						end else begin
							if (!pad_q && b == PAD_BYTE) begin
								pad_n = 1'b1;
							end else if (!pad_q) begin
								it_v    = 1'b1;
								it_kind = KIND_CHAR;
								it_idx  = addr_q;
								it_val  = {1'b0, b[7:1]};
							end
							bia_n = bia_q + 3'd1;
						end
					end else if (b[0]) begin
						// end of address field; the destination alone is too few
						if (addr_q == 4'd0) begin
							err_n = ST_BAD_ADDR_LEN;
						end else begin
							it_v    = 1'b1;
							it_kind = KIND_SSID;
							it_idx  = addr_q;
							it_val  = {4'd0, b[4:1]};
							phase_n = PH_CTRL;
						end
					end else if ({1'b0, addr_q} + 5'd1 >= ADDR_LIMIT) begin
						err_n = ST_TOO_MANY;
					end else begin
						it_v    = 1'b1;
						it_kind = KIND_SSID;
						it_idx  = addr_q;
						it_val  = {4'd0, b[4:1]};
						addr_n  = addr_q + 4'd1;
						bia_n   = 3'd0;
						pad_n   = 1'b0;
					end
				end
				PH_CTRL: begin
					if (b[1:0] != CTRL_UI) begin
						err_n = ST_NOT_UI;
					end else begin
						it_v    = 1'b1;
						it_kind = KIND_CONTROL;
						it_val  = b;
						phase_n = PH_PID;
					end
				end
				PH_PID: begin
					if (b != expected_pid) begin
						err_n = ST_BAD_PID;
					end else begin
						it_v    = 1'b1;
						it_kind = KIND_PID;
						it_val  = b;
						phase_n = PH_DATA;
					end
				end
				default: begin
					it_v    = 1'b1;
					it_kind = KIND_PAYLOAD;
					it_val  = b;
					if (pc_q != PLEN_MAX) begin
						pc_n = pc_q + 10'd1;
					end
				end
			endcase
		end

		// short wins over any other rejection
		if (CW'(bc_n) < CW'(min_frame_length)) begin
			stat = ST_SHORT;
		end else if (err_n != ST_OK) begin
			stat = err_n;
		end else if (phase_n == PH_ADDR) begin
			stat = ST_NO_ADDR_END;
		end else if (phase_n != PH_DATA) begin
			stat = ST_SHORT;
		end else begin
			stat = ST_OK;
		end
	end

	assign push = accept && (it_v || frame.last_byte);

	always_comb begin
		push_entry.item_v         = it_v;
		push_entry.kind           = it_kind;
		push_entry.address_index  = it_idx;
		push_entry.value          = it_val;
		push_entry.stat_v         = frame.last_byte;
		push_entry.status         = stat;
		push_entry.pay_len        = pc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q    <= '0;
			phase_q <= PH_ADDR;
			addr_q  <= 4'd0;
			bia_q   <= 3'd0;
			pad_q   <= 1'b0;
			err_q   <= ST_OK;
			pc_q    <= 10'd0;
		end else if (accept) begin
			if (frame.last_byte) begin
				bc_q    <= '0;
				phase_q <= PH_ADDR;
				addr_q  <= 4'd0;
				bia_q   <= 3'd0;
				pad_q   <= 1'b0;
				err_q   <= ST_OK;
				pc_q    <= 10'd0;
			end else begin
				bc_q    <= bc_n;
				phase_q <= phase_n;
				addr_q  <= addr_n;
				bia_q   <= bia_n;
				pad_q   <= pad_n;
				err_q   <= err_n;
				pc_q    <= pc_n;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame.last_byte) |=> (bc_q == '0 && err_q == ST_OK && pc_q == 10'd0))
		else $error("front state not cleared after frame end");
	a_phase_needs_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_ADDR) |-> (addr_q != 4'd0))
		else $error("left address field with fewer than two addresses");

endmodule

`default_nettype wire

/* src/ax25ui_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module ax25ui_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire ax25ui_pkg::queue_entry_t push_entry,
	output logic                         full,
	input  wire logic                    pop,
	output logic                         head_v,
	output ax25ui_pkg::queue_entry_t     head
);
	import ax25ui_pkg::*;

	queue_entry_t mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign full   = (cnt_q == (QAW+1)'(QDEPTH));
	assign head_v = (cnt_q != '0);
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue write while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_v)
		else $error("queue read while empty");
	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_entry.item_v || push_entry.stat_v))
		else $error("queue entry carries no result");

endmodule

`default_nettype wire

/* src/ax25ui_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ax25ui_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    head_v,
	input  wire ax25ui_pkg::queue_entry_t head,
	output logic                         pop,
	ax25ui_result_if.source              result
);
	import ax25ui_pkg::*;

	result_item_t out_q, pend_q;
	result_item_t head_item, head_stat;
	logic         out_v_q, pend_v_q;
	logic         out_free;

	always_comb begin
		head_item.kind           = head.kind;
		head_item.address_index  = head.address_index;
		head_item.value          = head.value;
		head_item.status         = ST_OK;
		head_item.pay_len        = 10'd0;
		head_item.frame_end      = 1'b0;

		head_stat.kind           = KIND_STATUS;
		head_stat.address_index  = 4'd0;
		head_stat.value          = 8'd0;
		head_stat.status         = head.status;
		head_stat.pay_len        = head.pay_len;
		head_stat.frame_end      = 1'b1;
	end

	assign out_free = !out_v_q || result.ready;
	// a pending status item goes out before the next entry is taken
	assign pop = out_free && !pend_v_q && head_v;

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_q <= pend_q;
			end else if (head_v) begin
				out_q <= head.item_v ? head_item : head_stat;
			end
		end
		if (pop) begin
			pend_q <= head_stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (out_free) begin
			if (pend_v_q) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else begin
				out_v_q  <= head_v;
				pend_v_q <= head_v && head.item_v && head.stat_v;
			end
		end
	end

	assign result.valid          = out_v_q;
	assign result.kind           = out_q.kind;
	assign result.address_index  = out_q.address_index;
	assign result.value          = out_q.value;
	assign result.status         = out_q.status;
	assign result.pay_len        = out_q.pay_len;
	assign result.frame_end      = out_q.frame_end;

	a_pend_behind_item: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (out_v_q && !out_q.frame_end))
		else $error("status held without an item ahead of it");
	a_end_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((out_q.kind == KIND_STATUS) == out_q.frame_end))
		else $error("frame end mark not on status item");

endmodule

`default_nettype wire

/* bench/ax25_ui_frame_parser_tb.sv */
`timescale 1ns / 1ps

module ax25_ui_frame_parser_tb;
	import ax25ui_pkg::*;

	// Build the block with its default limits and keep a copy for the predictor.
	localparam int ADDR_LIMIT  = 10;
	localparam int BYTE_LIMIT  = 1023;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PRINT_LIMIT = 40;

	// Where the predictor is within the frame.
	typedef enum logic [1:0] {AT_ADDRESS, AT_CONTROL, AT_PID, AT_PAYLOAD} parse_at_t;

	// Ways a random frame can be broken. Keep FAULT_NOISE last: the random
	// picker counts the faults by it.
	typedef enum int {
		FAULT_NONE,
		FAULT_CALL_END,        // end bit on a callsign byte
		FAULT_FIRST_SSID_END,  // end bit already on the destination SSID
		FAULT_NO_ADDR_END,     // address field never closed
		FAULT_TOO_MANY,        // one address more than the block takes
		FAULT_NOT_UI,          // control byte without the UI bits
		FAULT_BAD_PID,         // PID differs from the programmed one
		FAULT_CUT_AFTER_ADDR,  // frame stops right after the address field
		FAULT_CUT_AFTER_CTRL,  // frame stops right after the control byte
		FAULT_NOISE            // random bytes, random length
	} frame_fault_t;

	// One row of the directed table. Where typed is set, the status item of the
	// row is the one written here; everything else comes from the predictor.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		logic [2:0] st;
		logic [9:0] plen;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 19;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// lone bytes right after reset: both extremes, both too short
		'{8'hFF, 1'b1, 1'b1, ST_SHORT, 10'd0},
		'{8'h00, 1'b1, 1'b1, ST_SHORT, 10'd0},
		// destination "CQ", padded with shifted spaces, SSID byte with high bits set
		'{8'h86, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'hA2, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h40, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h40, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h40, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h40, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'hE0, 1'b0, 1'b0, ST_OK, 10'd0},
		// source "N0CALL", SSID 15 with the end bit
		'{8'h9C, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h60, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h86, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h82, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h98, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h98, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'h7F, 1'b0, 1'b0, ST_OK, 10'd0},
		// UI control, default PID, one payload byte: the shortest accepted frame plus one
		'{8'h03, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'hF0, 1'b0, 1'b0, ST_OK, 10'd0},
		'{8'hFF, 1'b1, 1'b1, ST_OK, 10'd1}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ax25ui_frame_if  frame_ch ();
	ax25ui_result_if result_ch ();

	ax25_ui_frame_parser #(
		.MAX_ADDRESSES  (ADDR_LIMIT),
		.MAX_FRAME_BYTES(BYTE_LIMIT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Register copies, reset values of the block.
	logic [9:0] min_len_reg = 10'd16;
	logic [7:0] pid_reg     = 8'hF0;

	// Parser state of the predictor.
	int         frame_bytes   = 0;
	parse_at_t  parse_at      = AT_ADDRESS;
	int         addr_num      = 0;
	int         addr_pos      = 0;
	bit         padding       = 1'b0;
	logic [2:0] reject        = ST_OK;
	int         payload_bytes = 0;

	// Results still owed by the block, oldest first.
	result_item_t pending_results [$];

	// Status given by the directed table for the byte now on the bus.
	bit         typed_status_on = 1'b0;
	logic [2:0] typed_status    = ST_OK;
	logic [9:0] typed_plen      = 10'd0;

	int idle_mode = 1;  // 0 no idling, 1 light, 2 heavy
	int cycles = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int status_seen [8];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Print one line per mismatch (up to a cap) and count all of them.
	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT)
			$display("[%0d] mismatch on %s: got 0x%0h, want 0x%0h (frame %0d)",
				cycles, what, got, want, frames_sent);
		mismatches++;
	endtask

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap(input int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == 0)
			return 0;
		if (mode == 1) begin
			if (r < 70) return 0;
			if (r < 94) return $urandom_range(1, 3);
			return $urandom_range(8, 30);
		end
		if (r < 35) return 0;
		if (r < 80) return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	function automatic void expect_item(input logic [2:0] kind, input int idx,
		input logic [7:0] val, input logic [2:0] st, input logic [9:0] plen,
		input logic fend);
		pending_results.push_back({kind, 4'(idx), val, st, plen, fend});
	endfunction

	// Advance the predictor by one accepted byte and queue the results it owes.
	function automatic void parse_byte(input logic [7:0] b, input logic last);
		logic [2:0] st;
		logic [9:0] plen;
		// count saturates one past the limit, so the overlong check fires once
		if (frame_bytes <= BYTE_LIMIT)
			frame_bytes++;
		if (reject == ST_OK && frame_bytes > BYTE_LIMIT) begin
			reject = ST_TOO_LONG;
		end else if (reject == ST_OK) begin
			case (parse_at)
				AT_ADDRESS: begin
					if (addr_pos < CALL_CHARS) begin
						// callsign position: an end bit here closes the address too early
						if (b[0]) begin
							reject = ST_BAD_ADDR_LEN;
						end else begin
							// first shifted space starts padding; padded bytes give nothing
							if (!padding && b == PAD_BYTE)
								padding = 1'b1;
							else if (!padding)
								expect_item(KIND_CHAR, addr_num, b >> 1, ST_OK, 10'd0, 1'b0);
							addr_pos++;
						end
					end else if (b[0]) begin
						// SSID with end bit: legal only once a source address exists
						if (addr_num < 1) begin
							reject = ST_BAD_ADDR_LEN;
						end else begin
							expect_item(KIND_SSID, addr_num, {4'b0, b[4:1]}, ST_OK, 10'd0, 1'b0);
							parse_at = AT_CONTROL;
						end
					end else if (addr_num + 1 >= ADDR_LIMIT) begin
						reject = ST_TOO_MANY;
					end else begin
						expect_item(KIND_SSID, addr_num, {4'b0, b[4:1]}, ST_OK, 10'd0, 1'b0);
						addr_num++;
						addr_pos = 0;
						padding = 1'b0;
					end
				end
				AT_CONTROL: begin
					if (b[1:0] != CTRL_UI) begin
						reject = ST_NOT_UI;
					end else begin
						expect_item(KIND_CONTROL, 0, b, ST_OK, 10'd0, 1'b0);
						parse_at = AT_PID;
					end
				end
				AT_PID: begin
					if (b != pid_reg) begin
						reject = ST_BAD_PID;
					end else begin
						expect_item(KIND_PID, 0, b, ST_OK, 10'd0, 1'b0);
						parse_at = AT_PAYLOAD;
					end
				end
				default: begin
					expect_item(KIND_PAYLOAD, 0, b, ST_OK, 10'd0, 1'b0);
					if (payload_bytes < PLEN_MAX)
						payload_bytes++;
				end
			endcase
		end

		if (last) begin
			// short wins over any rejection; a frame cut before its PID is short too
			if (frame_bytes < min_len_reg)
				st = ST_SHORT;
			else if (reject != ST_OK)
				st = reject;
			else if (parse_at == AT_ADDRESS)
				st = ST_NO_ADDR_END;
			else if (parse_at != AT_PAYLOAD)
				st = ST_SHORT;
			else
				st = ST_OK;
			plen = 10'(payload_bytes);
			if (typed_status_on) begin
				st = typed_status;
				plen = typed_plen;
			end
			expect_item(KIND_STATUS, 0, 8'h00, st, plen, 1'b1);
			// registers stay, the parse starts over
			frame_bytes = 0;
			parse_at = AT_ADDRESS;
			addr_num = 0;
			addr_pos = 0;
			padding = 1'b0;
			reject = ST_OK;
			payload_bytes = 0;
		end
	endfunction

	// Sample both channels at the rising edge. Check the result first; it always
	// belongs to bytes taken at earlier edges.
	always @(posedge clk) begin
		result_item_t got;
		result_item_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.kind, result_ch.address_index, result_ch.value,
					result_ch.status, result_ch.pay_len, result_ch.frame_end};
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending, kind", got.kind, -1);
				end else begin
					want = pending_results.pop_front();
					if (want.kind == KIND_STATUS)
						status_seen[want.status]++;
					if (got.kind != want.kind)
						report_mismatch("kind", got.kind, want.kind);
					if (got.address_index != want.address_index)
						report_mismatch("address_index", got.address_index, want.address_index);
					if (got.value != want.value)
						report_mismatch("value", got.value, want.value);
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.pay_len != want.pay_len)
						report_mismatch("pay_len", got.pay_len, want.pay_len);
					if (got.frame_end != want.frame_end)
						report_mismatch("frame_end", got.frame_end, want.frame_end);
				end
			end
			if (frame_ch.valid && frame_ch.ready)
				parse_byte(frame_ch.frame_byte, frame_ch.last_byte);
		end
	end

	// Result side: drop ready for random stretches, changing only at the falling edge.
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = pick_gap(idle_mode);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one byte, maybe after a gap, and hold it until the transfer. Called
	// and left at a falling edge; valid stays high so back-to-back bytes flow.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap(idle_mode);
		if (gap > 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.frame_byte <= b;
		frame_ch.last_byte <= last;
		do @(posedge clk); while (!frame_ch.ready);
		bytes_sent++;
		if (last)
			frames_sent++;
		@(negedge clk);
	endtask

	// One APB access: setup, access, hold until pready, then back to idle.
	task automatic apb_transfer(input logic write, input logic idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_registers();
		logic [31:0] rd;
		apb_transfer(1'b0, REG_MIN_LEN, 32'd0, rd);
		if (rd[9:0] != min_len_reg)
			report_mismatch("min_frame_length readback", rd[9:0], min_len_reg);
		apb_transfer(1'b0, REG_PID, 32'd0, rd);
		if (rd[7:0] != pid_reg)
			report_mismatch("expected_pid readback", rd[7:0], pid_reg);
	endtask

	// Stop offering bytes and let every owed result arrive, then wait on for
	// bytes that owe nothing but may still sit in the block.
	task automatic drain_results();
		frame_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [31:0] val);
		logic [31:0] rd;
		drain_results();
		apb_transfer(1'b1, idx, val, rd);
		if (idx == REG_MIN_LEN)
			min_len_reg = val[9:0];
		else
			pid_reg = val[7:0];
		reg_writes++;
	endtask

	// Mostly letters and digits, sometimes any 7-bit value (a space among them
	// opens padding early).
	function automatic logic [6:0] random_char();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 7'($urandom_range(0, 127));
		if (r < 3)
			return 7'h30 + 7'($urandom_range(0, 9));   // '0'..'9'
		return 7'h41 + 7'($urandom_range(0, 25));      // 'A'..'Z'
	endfunction

	// Build one frame, well formed unless a fault is asked for, and send it.
	// naddr_req of 0 picks the address count at random.
	task automatic send_frame(input frame_fault_t fault, input int naddr_req,
		input int payload_len);
		logic [7:0] frame_bytes_q [$];
		logic [7:0] b;
		int naddr;
		int nchar;
		int spot;
		if (fault == FAULT_NOISE) begin
			repeat ($urandom_range(1, 40))
				frame_bytes_q.push_back(8'($urandom));
		end else begin
			if (naddr_req > 0)
				naddr = naddr_req;
			else if ($urandom_range(0, 4) != 0)
				naddr = $urandom_range(2, 4);
			else
				naddr = $urandom_range(2, ADDR_LIMIT);
			if (fault == FAULT_TOO_MANY)
				naddr = ADDR_LIMIT + 1;

			for (int a = 0; a < naddr; a++) begin
				nchar = $urandom_range(1, CALL_CHARS);
				for (int c = 0; c < CALL_CHARS; c++) begin
					// after the first pad byte, anything even is ignored by the block
					if (c < nchar)
						b = {random_char(), 1'b0};
					else if (c > nchar && $urandom_range(0, 3) == 0)
						b = {7'($urandom), 1'b0};
					else
						b = PAD_BYTE;
					frame_bytes_q.push_back(b);
				end
				b = 8'($urandom);
				b[0] = (a == naddr - 1 && fault != FAULT_NO_ADDR_END) ||
					(a == 0 && fault == FAULT_FIRST_SSID_END);
				frame_bytes_q.push_back(b);
			end

			if (fault == FAULT_CALL_END) begin
				spot = $urandom_range(0, naddr - 1) * (CALL_CHARS + 1) +
					$urandom_range(0, CALL_CHARS - 1);
				frame_bytes_q[spot][0] = 1'b1;
			end
			// an open address field may also end in the middle of an address
			if (fault == FAULT_NO_ADDR_END)
				repeat ($urandom_range(0, CALL_CHARS))
					void'(frame_bytes_q.pop_back());

			if (fault != FAULT_NO_ADDR_END && fault != FAULT_CUT_AFTER_ADDR) begin
				b = 8'($urandom);
				if (fault == FAULT_NOT_UI)
					b[1:0] = 2'($urandom_range(0, 2));
				else
					b[1:0] = CTRL_UI;
				frame_bytes_q.push_back(b);
				if (fault != FAULT_CUT_AFTER_CTRL) begin
					b = pid_reg;
					if (fault == FAULT_BAD_PID)
						b = pid_reg ^ 8'($urandom_range(1, 255));
					frame_bytes_q.push_back(b);
					repeat (payload_len)
						frame_bytes_q.push_back(8'($urandom));
				end
			end
		end

		foreach (frame_bytes_q[i])
			send_byte(frame_bytes_q[i], i == frame_bytes_q.size() - 1);
	endtask

	// Random frames until about the given number of bytes has gone in. Roughly
	// half are clean; the rest spread over the fault kinds.
	task automatic run_random_frames(input int byte_budget);
		int start;
		int r;
		int plen;
		frame_fault_t fault;
		start = bytes_sent;
		while (bytes_sent - start < byte_budget) begin
			r = $urandom_range(0, 99);
			fault = FAULT_NONE;
			if (r >= 55)
				fault = frame_fault_t'(1 + (r - 55) % int'(FAULT_NOISE));
			if ($urandom_range(0, 3) == 0)
				plen = $urandom_range(0, 2);
			else
				plen = $urandom_range(0, 24);
			// with a raised minimum, land frames around the boundary too
			if (min_len_reg > 30 && $urandom_range(0, 1) == 1)
				plen = $urandom_range(min_len_reg - 30, min_len_reg + 8);
			send_frame(fault, 0, plen);
		end
	endtask

	// Watchdog: end the run if it hangs.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("run stopped at the cycle limit with %0d results pending",
			pending_results.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		// Known values on every input from time zero.
		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.frame_byte = 8'h00;
		frame_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers must come up at their reset values.
		check_registers();

		// Directed table: lone bytes after reset, then a clean frame with every kind.
		idle_mode = 1;
		foreach (DIRECTED[i]) begin
			typed_status_on = DIRECTED[i].typed;
			typed_status = DIRECTED[i].st;
			typed_plen = DIRECTED[i].plen;
			send_byte(DIRECTED[i].data, DIRECTED[i].last);
		end
		typed_status_on = 1'b0;

		// Reset settings, light idling.
		run_random_frames(170);

		// Largest minimum and PID zero: every frame comes out short, no idling.
		write_register(REG_MIN_LEN, 32'd1023);
		write_register(REG_PID, 32'h00);
		check_registers();
		idle_mode = 0;
		repeat (3)
			send_frame(FAULT_NONE, 2, $urandom_range(0, 40));

		// Minimum back at its reset value and PID all ones, heavy idling on both sides.
		write_register(REG_MIN_LEN, 32'd16);
		write_register(REG_PID, 32'hFF);
		check_registers();
		idle_mode = 2;
		run_random_frames(160);

		// Random mid settings.
		write_register(REG_MIN_LEN, 32'($urandom_range(17, 60)));
		write_register(REG_PID, 32'($urandom_range(0, 255)));
		check_registers();
		idle_mode = 1;
		run_random_frames(160);

		// Back to the reset settings, a stretch with no idling.
		write_register(REG_MIN_LEN, 32'd16);
		write_register(REG_PID, 32'hF0);
		check_registers();
		idle_mode = 0;
		run_random_frames(160);

		drain_results();
		repeat (10) @(posedge clk);

		$display("covered %0d frames, %0d bytes, %0d results, %0d register writes, %0d cycles",
			frames_sent, bytes_sent, results_checked, reg_writes, cycles);
		$display("status mix: ok %0d short %0d no-end %0d addr-len %0d too-many %0d %s",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_NO_ADDR_END],
			status_seen[ST_BAD_ADDR_LEN], status_seen[ST_TOO_MANY],
			$sformatf("not-ui %0d pid %0d too-long %0d; %0d mismatches",
				status_seen[ST_NOT_UI], status_seen[ST_BAD_PID],
				status_seen[ST_TOO_LONG], mismatches));
		if (mismatches == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
src/ax25ui_pkg.sv
src/ax25ui_frame_if.sv
src/ax25ui_result_if.sv
src/ax25ui_front.sv
src/ax25ui_queue.sv
src/ax25ui_back.sv
src/ax25_ui_frame_parser.sv
bench/ax25_ui_frame_parser_tb.sv
